// File: hdl/btc_pkg.sv
// Shared types, constants and codes for the button tap classifier.
package btc_pkg;

  localparam int TIME_BITS = 16;
  localparam int CFG_BITS  = 16;
  localparam int TAP_BITS  = 8;
  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;

  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_SINGLE = 2'd1;
  localparam logic [1:0] EV_DOUBLE = 2'd2;
  localparam logic [1:0] EV_LONG   = 2'd3;

  localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [1:0] REG_LONG_PRESS = 2'd1;
  localparam logic [1:0] REG_MULTI_TAP  = 2'd2;

  localparam logic [CFG_BITS-1:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [CFG_BITS-1:0] LONG_PRESS_RST = 16'd3000;
  localparam logic [CFG_BITS-1:0] MULTI_TAP_RST  = 16'd400;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_PIN  = 1'b1;

  typedef struct packed {
    logic action;
    logic pin_level;
  } cmd_t;

  typedef struct packed {
    logic [1:0] event_code;
    logic       held;
  } evt_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] debounce_ms;
    logic [CFG_BITS-1:0] long_press_ms;
    logic [CFG_BITS-1:0] multi_tap_ms;
  } cfg_t;

endpackage

// File: hdl/button_tap_classifier_top.sv
// Top level: register port, classifier core and result register with skid stage.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+--------------------------------
//   cmd      | cmd_valid / cmd_stall      | cmd.action, cmd.pin_level
//   evt      | evt_valid / evt_stall      | evt.event_code, evt.held
//   apb      | psel, penable, pready      | paddr, pwdata, prdata
//
// One request per cycle while cmd_stall is low; each result is registered in evt or skid.
// The core state update is a single pass of compares and increments.
// A skid stage holds one result while evt is stalled; cmd_stall rises only when it is full.
// Synchronous reset clears the core state, both valid flags and the registers to defaults.
module button_tap_classifier_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [btc_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [btc_pkg::DATA_BITS-1:0]   pwdata,
  output logic [btc_pkg::DATA_BITS-1:0]   prdata,
  output logic                            pready,
  input  logic                            cmd_valid,
  output logic                            cmd_stall,
  input  btc_pkg::cmd_t                   cmd,
  output logic                            evt_valid,
  input  logic                            evt_stall,
  output btc_pkg::evt_t                   evt
);

  btc_pkg::cfg_t cfg;
  btc_pkg::evt_t res;
  btc_pkg::evt_t skid;
  logic          skid_valid;
  logic          accept;
  logic          wr_en;
  logic [1:0]    reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[btc_pkg::ADDR_BITS-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms   <= btc_pkg::DEBOUNCE_RST;
      cfg.long_press_ms <= btc_pkg::LONG_PRESS_RST;
      cfg.multi_tap_ms  <= btc_pkg::MULTI_TAP_RST;
    end else if (wr_en) begin
      case (reg_sel)
        btc_pkg::REG_DEBOUNCE:   cfg.debounce_ms   <= pwdata[btc_pkg::CFG_BITS-1:0];
        btc_pkg::REG_LONG_PRESS: cfg.long_press_ms <= pwdata[btc_pkg::CFG_BITS-1:0];
        btc_pkg::REG_MULTI_TAP:  cfg.multi_tap_ms  <= pwdata[btc_pkg::CFG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      btc_pkg::REG_DEBOUNCE:   prdata = btc_pkg::DATA_BITS'(cfg.debounce_ms);
      btc_pkg::REG_LONG_PRESS: prdata = btc_pkg::DATA_BITS'(cfg.long_press_ms);
      btc_pkg::REG_MULTI_TAP:  prdata = btc_pkg::DATA_BITS'(cfg.multi_tap_ms);
      default:                 prdata = '0;
    endcase
  end

  assign cmd_stall = skid_valid;
  assign accept    = cmd_valid && !skid_valid;

  btc_core u_core (
    .clk (clk),
    .rst (rst),
    .en  (accept),
    .cmd (cmd),
    .cfg (cfg),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      evt_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (evt_valid && evt_stall) begin
      if (accept) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      evt_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      evt_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_valid && evt_stall) begin
      if (accept) begin
        skid <= res;
      end
    end else if (skid_valid) begin
      evt <= skid;
    end else if (accept) begin
      evt <= res;
    end
  end

endmodule

// File: hdl/btc_core.sv
// Debounce state, elapsed-time counters and tap classification for one request.
module btc_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  btc_pkg::cmd_t   cmd,
  input  btc_pkg::cfg_t   cfg,
  output btc_pkg::evt_t   res
);

  localparam logic [btc_pkg::TAP_BITS-1:0] TAP_ONE = btc_pkg::TAP_BITS'(1);
  localparam logic [btc_pkg::TAP_BITS-1:0] TAP_TWO = btc_pkg::TAP_BITS'(2);

  logic                            button_down, button_down_next;
  logic                            long_fired, long_fired_next;
  logic [btc_pkg::TAP_BITS-1:0]    tap_count, tap_count_next;
  logic [btc_pkg::TIME_BITS-1:0]   since_press, since_press_next;
  logic [btc_pkg::TIME_BITS-1:0]   since_release, since_release_next;
  logic [btc_pkg::TIME_BITS-1:0]   press_inc, release_inc;
  logic [1:0]                      ev;
  logic                            pressed;

  assign press_inc   = (since_press == '1) ? since_press : since_press + 1'b1;
  assign release_inc = (since_release == '1) ? since_release : since_release + 1'b1;
  assign pressed     = !cmd.pin_level;

  always_comb begin
    button_down_next   = button_down;
    long_fired_next    = long_fired;
    tap_count_next     = tap_count;
    since_press_next   = since_press;
    since_release_next = since_release;
    ev                 = btc_pkg::EV_NONE;
    if (cmd.action == btc_pkg::ACT_PIN) begin
      if (pressed && !button_down) begin
        if (since_release > btc_pkg::TIME_BITS'(cfg.debounce_ms)) begin
          button_down_next = 1'b1;
          since_press_next = '0;
        end
      end else if (!pressed && button_down) begin
        if (since_press > btc_pkg::TIME_BITS'(cfg.debounce_ms)) begin
          button_down_next   = 1'b0;
          since_release_next = '0;
          if (tap_count != '1) begin
            tap_count_next = tap_count + 1'b1;
          end
        end
      end
    end else begin
      since_press_next   = press_inc;
      since_release_next = release_inc;
      if (button_down && !long_fired &&
          press_inc >= btc_pkg::TIME_BITS'(cfg.long_press_ms)) begin
        long_fired_next = 1'b1;
        tap_count_next  = '0;
        ev              = btc_pkg::EV_LONG;
      end
      if (!button_down && long_fired) begin
        long_fired_next = 1'b0;
      end
      if (tap_count_next != '0 && !button_down &&
          release_inc > btc_pkg::TIME_BITS'(cfg.multi_tap_ms)) begin
        if (tap_count_next == TAP_ONE) begin
          ev = btc_pkg::EV_SINGLE;
        end else if (tap_count_next == TAP_TWO) begin
          ev = btc_pkg::EV_DOUBLE;
        end
        tap_count_next = '0;
      end
    end
  end

  assign res.event_code = ev;
  assign res.held       = button_down_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      button_down   <= 1'b0;
      long_fired    <= 1'b0;
      tap_count     <= '0;
      since_press   <= '0;
      since_release <= '0;
    end else if (en) begin
      button_down   <= button_down_next;
      long_fired    <= long_fired_next;
      tap_count     <= tap_count_next;
      since_press   <= since_press_next;
      since_release <= since_release_next;
    end
  end

endmodule

// File: hdl/btc_checker.sv
// Port-level checks for the button tap classifier, bound to the top level.
module btc_checker (
  input logic          clk,
  input logic          rst,
  input logic          pready,
  input logic          cmd_valid,
  input logic          cmd_stall,
  input logic          evt_valid,
  input logic          evt_stall,
  input btc_pkg::evt_t evt
);

  a_evt_hold: assert property (@(posedge clk) disable iff (rst)
    evt_valid && evt_stall |=> evt_valid && $stable(evt))
    else $error("stalled result changed");

  a_long_held: assert property (@(posedge clk) disable iff (rst)
    evt_valid && evt.event_code == btc_pkg::EV_LONG |-> evt.held)
    else $error("long press reported while released");

  a_tap_released: assert property (@(posedge clk) disable iff (rst)
    evt_valid && (evt.event_code == btc_pkg::EV_SINGLE ||
                  evt.event_code == btc_pkg::EV_DOUBLE) |-> !evt.held)
    else $error("tap reported while held");

  a_result_next: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall && (!evt_valid || !evt_stall) && pready |=> evt_valid)
    else $error("accepted request gave no result");

endmodule

bind button_tap_classifier_top btc_checker u_btc_checker (
  .clk       (clk),
  .rst       (rst),
  .pready    (pready),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .evt_valid (evt_valid),
  .evt_stall (evt_stall),
  .evt       (evt)
);

// File: tb/sv/tb.sv
// Testbench for the button tap classifier: directed, random and long-hold gestures checked by a model.
module tb;
  import btc_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int MAX_IDLE = 11;
  localparam int RANDOM_CMDS = 300;
  localparam int HOLD_OFF = 60;
  localparam int MAX_REPORTS = 100;
  localparam int TICK_CAP = 40;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam logic PIN_PRESSED = 1'b0;
  localparam logic PIN_RELEASED = 1'b1;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
  localparam logic [7:0] TAPS_MAX = 8'hff;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata;
  logic [DATA_BITS-1:0] prdata;
  logic pready;
  logic cmd_valid;
  logic cmd_stall;
  cmd_t cmd;
  logic evt_valid;
  logic evt_stall;
  evt_t evt;

  button_tap_classifier_top u_dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .evt_valid(evt_valid),
    .evt_stall(evt_stall),
    .evt(evt)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [CFG_BITS-1:0] cfg_ms [3] = '{DEBOUNCE_RST, LONG_PRESS_RST, MULTI_TAP_RST};
  logic btn_down = 1'b0;
  logic long_done = 1'b0;
  logic [7:0] taps = '0;
  logic [TIME_BITS-1:0] since_prs = '0;
  logic [TIME_BITS-1:0] since_rel = '0;

  evt_t pending_events[$];
  int n_errors = 0;
  int n_cmds = 0;
  int hold_req = 0;
  int quiet_cycles = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit evt_taken = 1'b0;

  function automatic evt_t classify(cmd_t c);
    evt_t r;
    r.event_code = EV_NONE;
    if (c.action == ACT_PIN) begin
      if (c.pin_level == PIN_PRESSED && !btn_down) begin
        if (since_rel > cfg_ms[REG_DEBOUNCE]) begin
          btn_down = 1'b1;
          since_prs = '0;
        end
      end else if (c.pin_level == PIN_RELEASED && btn_down) begin
        if (since_prs > cfg_ms[REG_DEBOUNCE]) begin
          btn_down = 1'b0;
          since_rel = '0;
          if (taps != TAPS_MAX) taps = taps + 8'd1;
        end
      end
    end else begin
      if (since_prs != TIME_MAX) since_prs = since_prs + 1'b1;
      if (since_rel != TIME_MAX) since_rel = since_rel + 1'b1;
      if (btn_down && !long_done && since_prs >= cfg_ms[REG_LONG_PRESS]) begin
        long_done = 1'b1;
        taps = '0;
        r.event_code = EV_LONG;
      end
      if (!btn_down && long_done) long_done = 1'b0;
      if (taps != 0 && !btn_down && since_rel > cfg_ms[REG_MULTI_TAP]) begin
        if (taps == 8'd1) r.event_code = EV_SINGLE;
        else if (taps == 8'd2) r.event_code = EV_DOUBLE;
        taps = '0;
      end
    end
    r.held = btn_down;
    return r;
  endfunction

  function automatic void flag(string field, longint want, longint got);
    n_errors++;
    if (n_errors <= MAX_REPORTS) $error("%s: expected %0d, got %0d", field, want, got);
  endfunction

  function automatic int cap_ms(logic [CFG_BITS-1:0] v);
    return (v > TICK_CAP) ? TICK_CAP : int'(v);
  endfunction

  function automatic logic [CFG_BITS-1:0] pick_ms(int hi);
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? '1 : '0;
    return CFG_BITS'($urandom_range(0, hi));
  endfunction

  task automatic send_cmd(cmd_t c);
    int gap;
    gap = tx_idle ? $urandom_range(0, MAX_IDLE) : 0;
    @(negedge clk);
    if (gap != 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    pending_events.push_back(classify(c));
    n_cmds++;
  endtask

  task automatic tick_ms(int n);
    cmd_t c;
    repeat (n) begin
      c.action = ACT_TICK;
      c.pin_level = 1'($urandom_range(0, 1));
      send_cmd(c);
    end
  endtask

  task automatic pin_change(logic level);
    cmd_t c;
    c.action = ACT_PIN;
    c.pin_level = level;
    send_cmd(c);
  endtask

  task automatic drain();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [DATA_BITS-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_BITS'({idx, 2'b00});
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx != REG_UNUSED) cfg_ms[idx] = value[CFG_BITS-1:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic reg_read(logic [1:0] idx);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_BITS'({idx, 2'b00});
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== DATA_BITS'(cfg_ms[idx])) flag("prdata", cfg_ms[idx], prdata);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(logic [CFG_BITS-1:0] dbnc, logic [CFG_BITS-1:0] long_ms,
                            logic [CFG_BITS-1:0] tap_ms);
    drain();
    reg_write(REG_DEBOUNCE, {CFG_BITS'($urandom), dbnc});
    reg_write(REG_LONG_PRESS, {CFG_BITS'($urandom), long_ms});
    reg_write(REG_MULTI_TAP, {CFG_BITS'($urandom), tap_ms});
  endtask

  task automatic tap_gesture(int n_taps, bit hold_long);
    int d;
    d = cap_ms(cfg_ms[REG_DEBOUNCE]);
    for (int t = 0; t < n_taps; t++) begin
      tick_ms(d + $urandom_range(0, 2));
      pin_change(PIN_PRESSED);
      if ($urandom_range(0, 3) == 0) begin
        pin_change(PIN_RELEASED);
        pin_change(PIN_PRESSED);
      end
      if (hold_long && t == n_taps - 1)
        tick_ms(cap_ms(cfg_ms[REG_LONG_PRESS]) + $urandom_range(0, 2));
      else
        tick_ms(d + $urandom_range(0, 2));
      pin_change(PIN_RELEASED);
    end
    tick_ms(cap_ms(cfg_ms[REG_MULTI_TAP]) + $urandom_range(0, 3));
  endtask

  task automatic test_registers();
    logic [1:0] regs [3];
    regs = '{REG_DEBOUNCE, REG_LONG_PRESS, REG_MULTI_TAP};
    foreach (regs[i]) reg_read(regs[i]);
    foreach (regs[i]) reg_write(regs[i], {CFG_BITS'($urandom), 16'hffff});
    foreach (regs[i]) reg_read(regs[i]);
    foreach (regs[i]) reg_write(regs[i], {CFG_BITS'($urandom), 16'h0000});
    foreach (regs[i]) reg_read(regs[i]);
    reg_write(REG_UNUSED, DATA_BITS'($urandom));
    foreach (regs[i]) reg_read(regs[i]);
  endtask

  // rejected and redundant edges, single tap, long press clearing a pending tap
  task automatic test_directed();
    set_config(16'd1, 16'd4, 16'd2);
    pin_change(PIN_PRESSED);
    pin_change(PIN_RELEASED);
    tick_ms(2);
    pin_change(PIN_PRESSED);
    pin_change(PIN_PRESSED);
    pin_change(PIN_RELEASED);
    tick_ms(2);
    pin_change(PIN_RELEASED);
    tick_ms(2);
    pin_change(PIN_PRESSED);
    tick_ms(4);
    pin_change(PIN_RELEASED);
    tick_ms(3);
  endtask

  task automatic test_output_backpressure();
    drain();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    hold_req = HOLD_OFF;
    repeat (30) send_cmd(cmd_t'($urandom_range(0, 3)));
    drain();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic test_tap_overflow();
    set_config(16'd0, 16'hffff, 16'd5);
    tick_ms(1);
    pin_change(PIN_RELEASED);
    tick_ms(8);
    repeat (6) begin
      pin_change(PIN_PRESSED);
      tick_ms(1);
      pin_change(PIN_RELEASED);
      tick_ms(1);
    end
    tick_ms(8);
  endtask

  task automatic test_random_gestures();
    int start;
    start = n_cmds;
    while (n_cmds - start < RANDOM_CMDS) begin
      set_config(pick_ms(4), pick_ms(30), pick_ms(12));
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 7) == 0)
          repeat ($urandom_range(1, 8)) send_cmd(cmd_t'($urandom_range(0, 3)));
        else
          tap_gesture($urandom_range(1, 4), $urandom_range(0, 3) == 0);
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic test_unreachable_debounce();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    set_config(16'hffff, 16'd1, 16'd0);
    tick_ms(2);
    pin_change(PIN_PRESSED);
    tick_ms(2);
    pin_change(PIN_RELEASED);
    tick_ms(2);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  always @(posedge clk) begin
    evt_t want;
    if (!rst && evt_valid && !evt_stall) begin
      evt_taken = 1'b1;
      if (pending_events.size() == 0) begin
        flag("unexpected result, event_code", -1, evt.event_code);
      end else begin
        want = pending_events.pop_front();
        if (evt.event_code !== want.event_code) flag("event_code", want.event_code, evt.event_code);
        if (evt.held !== want.held) flag("held", want.held, evt.held);
      end
    end
  end

  initial begin : rx_side
    int stall_left;
    stall_left = 0;
    evt_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        stall_left = hold_req;
        hold_req = 0;
      end else if (evt_taken) begin
        stall_left = rx_idle ? $urandom_range(0, MAX_IDLE) : 0;
      end
      evt_taken = 1'b0;
      evt_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (evt_valid && !evt_stall) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cmd_valid = 1'b0;
    cmd = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_registers();
    test_directed();
    test_output_backpressure();
    test_tap_overflow();
    test_random_gestures();
    test_unreachable_debounce();
    drain();
    repeat (4) @(posedge clk);
    if (n_errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
